>>> rtl/core/kcc_pkg.sv
// Shared types and constants for the k-means color clustering block.
`timescale 1ns / 1ps
`default_nettype none
package kcc_pkg;

   localparam int MAX_PIXELS   = 4096;
   localparam int MAX_CLUSTERS = 16;
   localparam int CHANNELS     = 3;

   localparam logic ACTION_PIXEL    = 1'b0;
   localparam logic ACTION_CENTROID = 1'b1;

   localparam logic [1:0] CSR_CLUSTER_COUNT = 2'd0;
   localparam logic [1:0] CSR_MAX_PASSES    = 2'd1;

   typedef struct packed {
      logic       action;
      logic [3:0] cluster_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [3:0]  result_cluster;
      logic [15:0] center_red;
      logic [15:0] center_green;
      logic [15:0] center_blue;
      logic [12:0] member_count;
      logic [7:0]  passes_run;
      logic        dropped_pixels;
      logic        final_result;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/core/kmeans_color_clustering.sv
// Lloyd k-means color clustering over a stored pixel stream.
// Load: one pixel or centroid item per cycle while busy is low.
// Run: each pass clears the accumulators, assigns every loaded pixel to its nearest
//   centroid, then runs the serial mean divider on each channel of every non-empty
//   cluster; an empty cluster keeps its centroid.
// Results: one cluster per cycle after the final pass; not stallable.
// Synchronous reset returns to idle, clears counters and centroids, restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module kmeans_color_clustering (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire kcc_pkg::req_type req,
   output logic                  rsp_valid,
   output kcc_pkg::rsp_type      rsp,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [7:0]       csr_data
);
   import kcc_pkg::*;

   localparam int AW    = $clog2(MAX_PIXELS);
   localparam int PIX_W = $clog2(MAX_PIXELS + 1);
   localparam int CI_W  = $clog2(MAX_CLUSTERS);
   localparam int CL_W  = $clog2(MAX_CLUSTERS + 1);
   localparam int SUM_W = PIX_W + 8;
   localparam int DIV_W = SUM_W + 8;
   localparam int DC_W  = $clog2(DIV_W + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_RDPIX, S_LATCH, S_SCAN, S_ACC,
      S_UPD, S_DIV, S_DIVEND, S_PASSEND, S_EMIT
   } state_type;

   state_type state_ff;

   logic [4:0]       cluster_count_ff;
   logic [7:0]       max_passes_ff;
   logic [CL_W-1:0]  k_ff;
   logic [7:0]       limit_ff;
   logic [PIX_W-1:0] loaded_ff;
   logic             overflow_ff;
   logic [7:0]       pass_ff;
   logic             changed_ff;

   logic [15:0]      cent_ff [MAX_CLUSTERS][CHANNELS];
   logic [SUM_W-1:0] sum_ff  [MAX_CLUSTERS][CHANNELS];
   logic [PIX_W-1:0] size_ff [MAX_CLUSTERS];

   // pixel walk and cluster scan
   logic [PIX_W-1:0] pix_idx_ff;
   logic [23:0]      pix_ff;
   logic [CL_W-1:0]  scan_ff;
   logic             issue_ff;
   logic             s1_v_ff, s2_v_ff;
   logic [CL_W-1:0]  s1_j_ff, s2_j_ff;
   logic [15:0]      s1_d_ff [CHANNELS];
   logic [31:0]      s2_sq_ff [CHANNELS];
   logic [33:0]      best_d_ff;
   logic [CL_W-1:0]  best_j_ff;

   // update sequencer and divider
   logic [CL_W-1:0]  uj_ff;
   logic [1:0]       uc_ff;
   logic [PIX_W:0]   rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DC_W-1:0]  dcnt_ff;

   logic             accept;
   logic             pix_we;
   logic [23:0]      ram_rdata;
   logic [CL_W-1:0]  k_in;
   logic [33:0]      sq_dist;
   logic [PIX_W:0]   shifted;
   logic [PIX_W:0]   divisor;
   logic [7:0]       pix_ch [CHANNELS];

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign pix_we    = accept && (req.action == ACTION_PIXEL) &&
                      (32'(loaded_ff) < MAX_PIXELS);

   kcc_ram #(.WIDTH(24), .DEPTH(MAX_PIXELS)) u_pixel_ram (
      .clock   (clock),
      .wr_en   (pix_we),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data ({req.red, req.green, req.blue}),
      .rd_addr (pix_idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (cluster_count_ff == 5'd0) begin
         k_in = CL_W'(1);
      end else if (32'(cluster_count_ff) > MAX_CLUSTERS) begin
         k_in = CL_W'(MAX_CLUSTERS);
      end else begin
         k_in = CL_W'(cluster_count_ff);
      end
   end

   assign pix_ch[0] = pix_ff[23:16];
   assign pix_ch[1] = pix_ff[15:8];
   assign pix_ch[2] = pix_ff[7:0];

   assign sq_dist = 34'(s2_sq_ff[0]) + 34'(s2_sq_ff[1]) + 34'(s2_sq_ff[2]);
   assign shifted = {rem_ff[PIX_W-1:0], quo_ff[DIV_W-1]};
   assign divisor = {1'b0, size_ff[uj_ff[CI_W-1:0]]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         cluster_count_ff <= 5'd4;
         max_passes_ff    <= 8'd64;
         loaded_ff        <= '0;
         overflow_ff      <= 1'b0;
         pass_ff          <= '0;
         rsp_valid        <= 1'b0;
         issue_ff         <= 1'b0;
         s1_v_ff          <= 1'b0;
         s2_v_ff          <= 1'b0;
         for (int c = 0; c < MAX_CLUSTERS; c++) begin
            for (int h = 0; h < CHANNELS; h++) begin
               cent_ff[c][h] <= '0;
            end
         end
      end else begin
         rsp_valid <= (state_ff == S_EMIT);

         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CLUSTER_COUNT) begin
               cluster_count_ff <= csr_data[4:0];
            end else if (csr_index == CSR_MAX_PASSES) begin
               max_passes_ff <= csr_data;
            end
         end

         // scan pipeline: absolute differences, then squares
         s1_v_ff <= issue_ff;
         s1_j_ff <= scan_ff;
         for (int h = 0; h < CHANNELS; h++) begin
            if ({pix_ch[h], 8'd0} >= cent_ff[scan_ff[CI_W-1:0]][h]) begin
               s1_d_ff[h] <= {pix_ch[h], 8'd0} - cent_ff[scan_ff[CI_W-1:0]][h];
            end else begin
               s1_d_ff[h] <= cent_ff[scan_ff[CI_W-1:0]][h] - {pix_ch[h], 8'd0};
            end
         end
         s2_v_ff <= s1_v_ff;
         s2_j_ff <= s1_j_ff;
         for (int h = 0; h < CHANNELS; h++) begin
            s2_sq_ff[h] <= s1_d_ff[h] * s1_d_ff[h];
         end
         // ties keep the lower index
         if (s2_v_ff && (s2_j_ff == '0 || sq_dist < best_d_ff)) begin
            best_d_ff <= sq_dist;
            best_j_ff <= s2_j_ff;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req.action == ACTION_CENTROID) begin
                     if (32'(req.cluster_index) < MAX_CLUSTERS) begin
                        cent_ff[req.cluster_index[CI_W-1:0]][0] <= {req.red, 8'd0};
                        cent_ff[req.cluster_index[CI_W-1:0]][1] <= {req.green, 8'd0};
                        cent_ff[req.cluster_index[CI_W-1:0]][2] <= {req.blue, 8'd0};
                     end
                  end else begin
                     if (pix_we) begin
                        loaded_ff <= loaded_ff + 1'b1;
                     end else begin
                        overflow_ff <= 1'b1;
                     end
                     if (req.last) begin
                        k_ff     <= k_in;
                        limit_ff <= (max_passes_ff == 8'd0) ? 8'd1 : max_passes_ff;
                        pass_ff  <= '0;
                        state_ff <= S_CLEAR;
                     end
                  end
               end
            end

            S_CLEAR: begin
               for (int c = 0; c < MAX_CLUSTERS; c++) begin
                  size_ff[c] <= '0;
                  for (int h = 0; h < CHANNELS; h++) begin
                     sum_ff[c][h] <= '0;
                  end
               end
               pix_idx_ff <= '0;
               changed_ff <= 1'b0;
               uj_ff      <= '0;
               uc_ff      <= '0;
               state_ff   <= (loaded_ff == '0) ? S_UPD : S_RDPIX;
            end

            S_RDPIX: begin
               state_ff <= S_LATCH;
            end

            S_LATCH: begin
               pix_ff   <= ram_rdata;
               scan_ff  <= '0;
               issue_ff <= 1'b1;
               state_ff <= S_SCAN;
            end

            S_SCAN: begin
               if (issue_ff) begin
                  if (scan_ff + 1'b1 == k_ff) begin
                     issue_ff <= 1'b0;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                  end
               end
               if (s2_v_ff && (s2_j_ff + 1'b1 == k_ff)) begin
                  state_ff <= S_ACC;
               end
            end

            S_ACC: begin
               size_ff[best_j_ff[CI_W-1:0]] <= size_ff[best_j_ff[CI_W-1:0]] + 1'b1;
               for (int h = 0; h < CHANNELS; h++) begin
                  sum_ff[best_j_ff[CI_W-1:0]][h] <=
                     sum_ff[best_j_ff[CI_W-1:0]][h] + SUM_W'(pix_ch[h]);
               end
               pix_idx_ff <= pix_idx_ff + 1'b1;
               if (pix_idx_ff + 1'b1 == loaded_ff) begin
                  state_ff <= S_UPD;
               end else begin
                  state_ff <= S_RDPIX;
               end
            end

            S_UPD: begin
               if (uj_ff == k_ff) begin
                  state_ff <= S_PASSEND;
               end else if (size_ff[uj_ff[CI_W-1:0]] == '0) begin
                  // empty cluster keeps its centroid
                  uj_ff <= uj_ff + 1'b1;
               end else begin
                  rem_ff   <= '0;
                  quo_ff   <= {sum_ff[uj_ff[CI_W-1:0]][uc_ff], 8'd0};
                  dcnt_ff  <= '0;
                  state_ff <= S_DIV;
               end
            end

            S_DIV: begin
               if (shifted >= divisor) begin
                  rem_ff <= shifted - divisor;
                  quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
               end else begin
                  rem_ff <= shifted;
                  quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff + 1'b1 == DC_W'(DIV_W)) begin
                  state_ff <= S_DIVEND;
               end
            end

            S_DIVEND: begin
               if (quo_ff[15:0] != cent_ff[uj_ff[CI_W-1:0]][uc_ff]) begin
                  changed_ff <= 1'b1;
               end
               cent_ff[uj_ff[CI_W-1:0]][uc_ff] <= quo_ff[15:0];
               if (uc_ff == 2'(CHANNELS - 1)) begin
                  uc_ff <= '0;
                  uj_ff <= uj_ff + 1'b1;
               end else begin
                  uc_ff <= uc_ff + 1'b1;
               end
               state_ff <= S_UPD;
            end

            S_PASSEND: begin
               pass_ff <= pass_ff + 1'b1;
               scan_ff <= '0;
               if (!changed_ff || (pass_ff + 1'b1 >= limit_ff)) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_CLEAR;
               end
            end

            S_EMIT: begin
               rsp.result_cluster <= 4'(scan_ff);
               rsp.center_red     <= cent_ff[scan_ff[CI_W-1:0]][0];
               rsp.center_green   <= cent_ff[scan_ff[CI_W-1:0]][1];
               rsp.center_blue    <= cent_ff[scan_ff[CI_W-1:0]][2];
               rsp.member_count   <= 13'(size_ff[scan_ff[CI_W-1:0]]);
               rsp.passes_run     <= pass_ff;
               rsp.dropped_pixels <= overflow_ff;
               rsp.final_result   <= (scan_ff + 1'b1 == k_ff);
               scan_ff            <= scan_ff + 1'b1;
               if (scan_ff + 1'b1 == k_ff) begin
                  loaded_ff   <= '0;
                  overflow_ff <= 1'b0;
                  state_ff    <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/kcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kcc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
